>>> rtl/scpa_pkg.sv
`default_nettype none

package scpa_pkg;

  // Geometry of the allocator.
  localparam int NUM_CLASSES     = 8;
  localparam int MIN_CLASS_BYTES = 16;
  localparam int NODE_COUNT      = 1024;

  // Field widths.
  localparam int HANDLE_W = 10;
  localparam int CLASS_W  = 3;
  localparam int REQ_W    = 24;
  localparam int BYTES_W  = 19;
  localparam int COUNT_W  = 11;
  localparam int HELD_W   = 32;
  localparam int FLIM_W   = 10;
  localparam int BLIM_W   = 32;
  localparam int PROD_W   = COUNT_W + BYTES_W;
  localparam int CMP_W    = (PROD_W > BLIM_W) ? PROD_W : BLIM_W;

  // Register reset values.
  localparam logic [FLIM_W-1:0] HOLD_FREE_LIMIT_RST = FLIM_W'(10);
  localparam logic [BLIM_W-1:0] HOLD_BYTE_LIMIT_RST = BLIM_W'(2000000);

  // Configuration register indexes.
  typedef enum logic {
    REG_HOLD_FREE_LIMIT = 1'b0,
    REG_HOLD_BYTE_LIMIT = 1'b1
  } cfg_reg_t;

  // Request types.
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_type_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_TOO_BIG    = 2'd1,
    ST_TABLE_FULL = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  // One entry of the node memory.
  typedef struct packed {
    logic [HANDLE_W-1:0] next_node;
    logic [CLASS_W-1:0]  node_class;
    logic                in_use;
    logic                backed;
  } node_entry_t;

  // Block size of a class: each class is four times the one before it.
  function automatic logic [BYTES_W-1:0] class_bytes(input logic [CLASS_W-1:0] c);
    return BYTES_W'(MIN_CLASS_BYTES) << {c, 1'b0};
  endfunction

endpackage

`default_nettype wire

>>> rtl/size_class_pool_allocator.sv
// Size-class handle allocator.
// Input channel (in_*): one request per transaction. in_req_type selects
// allocate (in_request_bytes) or free (in_release_handle). The block takes
// the transaction when in_valid is high and in_stall is low.
// Result channel (out_*): exactly one result per request, with status,
// handle, class size, class index, backing flags and the held byte total.
// The result is taken when out_valid is high and out_stall is low.
// Configuration (cfg_*): cfg_index 0 writes hold_free_limit, 1 writes
// hold_byte_limit; cfg_ready is always high.
// Each request runs through S_IDLE and S_EXEC: the read of the node memory
// entry (the class head for a pop, the released node for a free) is issued
// in the accept cycle, and S_EXEC updates the class lists and writes the
// entry back. A new request is taken only in S_IDLE, after the update of
// the last one is done; the result is registered as S_EXEC ends.
// The result sits in an output register, so a new request is taken while a
// stalled result waits; a second result waits in the update cycle until the
// output register frees up.
// Synchronous reset empties all class lists and the node table and restores
// the configuration defaults. The node memory itself is not cleared: the
// count of created nodes marks which entries are valid.
`default_nettype none

module size_class_pool_allocator (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // Request channel
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire                                  in_req_type,
  input  wire  [scpa_pkg::REQ_W-1:0]           in_request_bytes,
  input  wire  [scpa_pkg::HANDLE_W-1:0]        in_release_handle,
  // Result channel
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic [1:0]                           out_status,
  output logic [scpa_pkg::HANDLE_W-1:0]        out_granted_handle,
  output logic [scpa_pkg::BYTES_W-1:0]         out_granted_bytes,
  output logic [scpa_pkg::CLASS_W-1:0]         out_size_class,
  output logic                                 out_needs_backing,
  output logic                                 out_drop_backing,
  output logic [scpa_pkg::HELD_W-1:0]          out_held_bytes,
  // Configuration channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire                                  cfg_index,
  input  wire  [scpa_pkg::BLIM_W-1:0]          cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state_r, state_nxt;

  // Configuration registers
  logic [scpa_pkg::FLIM_W-1:0] hold_free_limit_r, hold_free_limit_nxt;
  logic [scpa_pkg::BLIM_W-1:0] hold_byte_limit_r, hold_byte_limit_nxt;

  // Class list state
  logic [scpa_pkg::HANDLE_W-1:0] class_head_r       [scpa_pkg::NUM_CLASSES];
  logic [scpa_pkg::HANDLE_W-1:0] class_head_nxt     [scpa_pkg::NUM_CLASSES];
  logic [scpa_pkg::COUNT_W-1:0]  class_free_count_r [scpa_pkg::NUM_CLASSES];
  logic [scpa_pkg::COUNT_W-1:0]  class_free_count_nxt [scpa_pkg::NUM_CLASSES];
  logic [scpa_pkg::COUNT_W-1:0]  nodes_created_r, nodes_created_nxt;
  logic [scpa_pkg::HELD_W-1:0]   bytes_held_r, bytes_held_nxt;

  // Request captured at accept
  logic                          req_type_r, req_type_nxt;
  logic [scpa_pkg::CLASS_W-1:0]  req_class_r, req_class_nxt;
  logic                          too_big_r, too_big_nxt;
  logic                          bad_range_r, bad_range_nxt;
  logic [scpa_pkg::HANDLE_W-1:0] handle_r, handle_nxt;

  // Output register
  logic                          out_valid_r, out_valid_nxt;
  logic [1:0]                    out_status_r, out_status_nxt;
  logic [scpa_pkg::HANDLE_W-1:0] out_handle_r, out_handle_nxt;
  logic [scpa_pkg::BYTES_W-1:0]  out_bytes_r, out_bytes_nxt;
  logic [scpa_pkg::CLASS_W-1:0]  out_class_r, out_class_nxt;
  logic                          out_nb_r, out_nb_nxt;
  logic                          out_db_r, out_db_nxt;

  // Node memory
  scpa_pkg::node_entry_t         node_mem [scpa_pkg::NODE_COUNT];
  scpa_pkg::node_entry_t         rd_data_r;
  scpa_pkg::node_entry_t         mem_wdata;
  logic                          mem_we;
  logic                          mem_re;
  logic [scpa_pkg::HANDLE_W-1:0] mem_waddr;
  logic [scpa_pkg::HANDLE_W-1:0] mem_raddr;

  // Datapath helpers
  logic [scpa_pkg::CLASS_W-1:0]  in_class;
  logic                          in_too_big;
  logic [scpa_pkg::CLASS_W-1:0]  free_class;
  logic [scpa_pkg::CLASS_W-1:0]  eff_class;
  logic [scpa_pkg::CLASS_W-1:0]  cls_idx;
  logic [scpa_pkg::HANDLE_W-1:0] cls_head;
  logic [scpa_pkg::COUNT_W-1:0]  cls_free;
  logic [scpa_pkg::COUNT_W-1:0]  fc_inc;
  logic [scpa_pkg::BYTES_W-1:0]  sz;
  logic [scpa_pkg::PROD_W-1:0]   held_prod;
  logic                          drop;
  logic                          out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;

  // Smallest class that fits the request.
  always_comb begin
    in_class   = '0;
    in_too_big = in_request_bytes >
                 scpa_pkg::REQ_W'(scpa_pkg::class_bytes(
                   scpa_pkg::CLASS_W'(scpa_pkg::NUM_CLASSES - 1)));
    for (int i = scpa_pkg::NUM_CLASSES - 1; i >= 0; i--) begin
      if (scpa_pkg::REQ_W'(scpa_pkg::class_bytes(scpa_pkg::CLASS_W'(i))) >=
          in_request_bytes) begin
        in_class = scpa_pkg::CLASS_W'(i);
      end
    end
  end

  // Class of a freed node comes from its memory entry.
  assign free_class = (int'(rd_data_r.node_class) >= scpa_pkg::NUM_CLASSES) ?
                      '0 : rd_data_r.node_class;
  assign eff_class  = (req_type_r == scpa_pkg::REQ_FREE) ? free_class : req_class_r;

  // One shared read port into the class registers.
  assign cls_idx  = (state_r == S_IDLE) ? in_class : eff_class;
  assign cls_head = class_head_r[cls_idx];
  assign cls_free = class_free_count_r[cls_idx];

  // Drop test for a free: count and held bytes of the class above limits, node still backed.
  assign sz        = scpa_pkg::class_bytes(eff_class);
  assign fc_inc    = cls_free + scpa_pkg::COUNT_W'(1);
  assign held_prod = scpa_pkg::PROD_W'(fc_inc) * scpa_pkg::PROD_W'(sz);
  assign drop      = (fc_inc > scpa_pkg::COUNT_W'(hold_free_limit_r)) &&
                     (scpa_pkg::CMP_W'(held_prod) >
                      scpa_pkg::CMP_W'(hold_byte_limit_r)) &&
                     rd_data_r.backed;

  // Main control: accept, then update and write back.
  always_comb begin
    state_nxt            = state_r;
    hold_free_limit_nxt  = hold_free_limit_r;
    hold_byte_limit_nxt  = hold_byte_limit_r;
    class_head_nxt       = class_head_r;
    class_free_count_nxt = class_free_count_r;
    nodes_created_nxt    = nodes_created_r;
    bytes_held_nxt       = bytes_held_r;
    req_type_nxt         = req_type_r;
    req_class_nxt        = req_class_r;
    too_big_nxt          = too_big_r;
    bad_range_nxt        = bad_range_r;
    handle_nxt           = handle_r;
    out_valid_nxt        = out_valid_r && out_stall;
    out_status_nxt       = out_status_r;
    out_handle_nxt       = out_handle_r;
    out_bytes_nxt        = out_bytes_r;
    out_class_nxt        = out_class_r;
    out_nb_nxt           = out_nb_r;
    out_db_nxt           = out_db_r;
    mem_re               = 1'b0;
    mem_raddr            = '0;
    mem_we               = 1'b0;
    mem_waddr            = '0;
    mem_wdata            = '0;

    // Configuration writes
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        scpa_pkg::REG_HOLD_FREE_LIMIT: hold_free_limit_nxt = cfg_data[scpa_pkg::FLIM_W-1:0];
        scpa_pkg::REG_HOLD_BYTE_LIMIT: hold_byte_limit_nxt = cfg_data;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_type_nxt  = in_req_type;
          req_class_nxt = in_class;
          too_big_nxt   = in_too_big;
          bad_range_nxt = {1'b0, in_release_handle} >= nodes_created_r;
          handle_nxt    = in_release_handle;
          mem_re        = 1'b1;
          mem_raddr     = (in_req_type == scpa_pkg::REQ_FREE) ? in_release_handle : cls_head;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = scpa_pkg::ST_OK;
          out_handle_nxt = '0;
          out_bytes_nxt  = '0;
          out_class_nxt  = '0;
          out_nb_nxt     = 1'b0;
          out_db_nxt     = 1'b0;
          state_nxt      = S_IDLE;
          if (req_type_r == scpa_pkg::REQ_ALLOC) begin
            priority if (too_big_r) begin
              out_status_nxt = scpa_pkg::ST_TOO_BIG;
            end else if (cls_free != '0) begin
              // Pop the head of the class free list.
              out_handle_nxt = cls_head;
              out_bytes_nxt  = sz;
              out_class_nxt  = eff_class;
              out_nb_nxt     = !rd_data_r.backed;
              if (!rd_data_r.backed) begin
                bytes_held_nxt = bytes_held_r + scpa_pkg::HELD_W'(sz);
              end
              class_head_nxt[eff_class]       = rd_data_r.next_node;
              class_free_count_nxt[eff_class] = cls_free - scpa_pkg::COUNT_W'(1);
              mem_we               = 1'b1;
              mem_waddr            = cls_head;
              mem_wdata            = rd_data_r;
              mem_wdata.in_use     = 1'b1;
              mem_wdata.backed     = 1'b1;
            end else if (nodes_created_r >= scpa_pkg::COUNT_W'(scpa_pkg::NODE_COUNT)) begin
              out_status_nxt = scpa_pkg::ST_TABLE_FULL;
            end else begin
              // Create a fresh node at the end of the table.
              out_handle_nxt       = nodes_created_r[scpa_pkg::HANDLE_W-1:0];
              out_bytes_nxt        = sz;
              out_class_nxt        = eff_class;
              out_nb_nxt           = 1'b1;
              bytes_held_nxt       = bytes_held_r + scpa_pkg::HELD_W'(sz);
              nodes_created_nxt    = nodes_created_r + scpa_pkg::COUNT_W'(1);
              mem_we               = 1'b1;
              mem_waddr            = nodes_created_r[scpa_pkg::HANDLE_W-1:0];
              mem_wdata.node_class = eff_class;
              mem_wdata.in_use     = 1'b1;
              mem_wdata.backed     = 1'b1;
            end
          end else begin
            if (bad_range_r || !rd_data_r.in_use) begin
              out_status_nxt = scpa_pkg::ST_BAD_HANDLE;
            end else begin
              // Push the node onto its class list, dropping backing if over limits.
              out_handle_nxt = handle_r;
              out_bytes_nxt  = sz;
              out_class_nxt  = eff_class;
              out_db_nxt     = drop;
              if (drop) begin
                bytes_held_nxt = bytes_held_r - scpa_pkg::HELD_W'(sz);
              end
              class_head_nxt[eff_class]       = handle_r;
              class_free_count_nxt[eff_class] = fc_inc;
              mem_we               = 1'b1;
              mem_waddr            = handle_r;
              mem_wdata.next_node  = cls_head;
              mem_wdata.node_class = eff_class;
              mem_wdata.in_use     = 1'b0;
              mem_wdata.backed     = rd_data_r.backed && !drop;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and bookkeeping registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r            <= S_IDLE;
      hold_free_limit_r  <= scpa_pkg::HOLD_FREE_LIMIT_RST;
      hold_byte_limit_r  <= scpa_pkg::HOLD_BYTE_LIMIT_RST;
      nodes_created_r    <= '0;
      bytes_held_r       <= '0;
      out_valid_r        <= 1'b0;
      for (int i = 0; i < scpa_pkg::NUM_CLASSES; i++) begin
        class_head_r[i]       <= '0;
        class_free_count_r[i] <= '0;
      end
    end else begin
      state_r            <= state_nxt;
      hold_free_limit_r  <= hold_free_limit_nxt;
      hold_byte_limit_r  <= hold_byte_limit_nxt;
      nodes_created_r    <= nodes_created_nxt;
      bytes_held_r       <= bytes_held_nxt;
      out_valid_r        <= out_valid_nxt;
      class_head_r       <= class_head_nxt;
      class_free_count_r <= class_free_count_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    req_type_r   <= req_type_nxt;
    req_class_r  <= req_class_nxt;
    too_big_r    <= too_big_nxt;
    bad_range_r  <= bad_range_nxt;
    handle_r     <= handle_nxt;
    out_status_r <= out_status_nxt;
    out_handle_r <= out_handle_nxt;
    out_bytes_r  <= out_bytes_nxt;
    out_class_r  <= out_class_nxt;
    out_nb_r     <= out_nb_nxt;
    out_db_r     <= out_db_nxt;
  end

  // Node memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      node_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= node_mem[mem_raddr];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_granted_handle = out_handle_r;
  assign out_granted_bytes  = out_bytes_r;
  assign out_size_class     = out_class_r;
  assign out_needs_backing  = out_nb_r;
  assign out_drop_backing   = out_db_r;
  assign out_held_bytes     = bytes_held_r;

endmodule

`default_nettype wire

>>> sim/alloc_checker.sv
`default_nettype none

// Watches the request, result and register channels of the allocator.
// It predicts each result, compares it with what the block returns, and
// reports the number of failures to the testbench top.
module alloc_checker
  import scpa_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  wire                 in_req_type,
  input  wire  [REQ_W-1:0]    in_request_bytes,
  input  wire  [HANDLE_W-1:0] in_release_handle,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  wire  [1:0]          out_status,
  input  wire  [HANDLE_W-1:0] out_granted_handle,
  input  wire  [BYTES_W-1:0]  out_granted_bytes,
  input  wire  [CLASS_W-1:0]  out_size_class,
  input  wire                 out_needs_backing,
  input  wire                 out_drop_backing,
  input  wire  [HELD_W-1:0]   out_held_bytes,
  input  wire                 cfg_valid,
  input  wire                 cfg_ready,
  input  wire                 cfg_index,
  input  wire  [BLIM_W-1:0]   cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  nodes_made
);

  // One result as the block should return it.
  typedef struct packed {
    status_t             status;
    logic [HANDLE_W-1:0] handle;
    logic [BYTES_W-1:0]  bytes;
    logic [CLASS_W-1:0]  cls;
    logic                needs;
    logic                drop;
    logic [HELD_W-1:0]   held;
  } grant_t;

  // Shadow copy of the allocator state and its registers.
  logic [HANDLE_W-1:0] list_head [NUM_CLASSES];
  logic [COUNT_W-1:0]  list_free [NUM_CLASSES];
  logic [HANDLE_W-1:0] link_next [NODE_COUNT];
  logic [CLASS_W-1:0]  node_cls  [NODE_COUNT];
  logic                busy      [NODE_COUNT];
  logic                backed    [NODE_COUNT];
  logic [COUNT_W-1:0]  created;
  logic [HELD_W-1:0]   held_total;
  logic [FLIM_W-1:0]   free_limit;
  logic [BLIM_W-1:0]   byte_limit;

  grant_t grant_q[$];
  int     errors;

  function automatic logic [BYTES_W-1:0] block_size(input int c);
    return BYTES_W'(MIN_CLASS_BYTES) << (2 * c);
  endfunction

  // Applies one request to the shadow state and returns its result.
  function automatic grant_t serve_request(input logic rtype,
                                           input logic [REQ_W-1:0] want,
                                           input logic [HANDLE_W-1:0] h);
    grant_t              r;
    int                  c;
    logic [HANDLE_W-1:0] node;
    logic [BYTES_W-1:0]  sz;
    r = '0;
    r.status = ST_OK;
    if (rtype == REQ_ALLOC) begin
      if (want > REQ_W'(block_size(NUM_CLASSES - 1))) begin
        r.status = ST_TOO_BIG;
      end else begin
        c = 0;
        while (c < NUM_CLASSES - 1 && want > REQ_W'(block_size(c))) c++;
        sz = block_size(c);
        if (list_free[c] != 0) begin
          // Pop the class list; a node whose backing was dropped gets new backing.
          node = list_head[c];
          if (!backed[node]) begin
            backed[node] = 1'b1;
            held_total   = held_total + HELD_W'(sz);
            r.needs      = 1'b1;
          end
          list_head[c] = link_next[node];
          list_free[c] = list_free[c] - 1'b1;
          busy[node]   = 1'b1;
          r.handle     = node;
          r.bytes      = sz;
          r.cls        = CLASS_W'(c);
        end else if (created >= COUNT_W'(NODE_COUNT)) begin
          r.status = ST_TABLE_FULL;
        end else begin
          // Take a fresh node from the table.
          node           = HANDLE_W'(created);
          created        = created + 1'b1;
          node_cls[node] = CLASS_W'(c);
          busy[node]     = 1'b1;
          backed[node]   = 1'b1;
          held_total     = held_total + HELD_W'(sz);
          r.needs        = 1'b1;
          r.handle       = node;
          r.bytes        = sz;
          r.cls          = CLASS_W'(c);
        end
      end
    end else begin
      if (COUNT_W'(h) >= created || !busy[h]) begin
        r.status = ST_BAD_HANDLE;
      end else begin
        c  = node_cls[h];
        sz = block_size(c);
        list_free[c] = list_free[c] + 1'b1;
        busy[h]      = 1'b0;
        // Drop the backing once the class holds too many free nodes and bytes.
        if (list_free[c] > COUNT_W'(free_limit) &&
            64'(list_free[c]) * 64'(sz) > 64'(byte_limit) && backed[h]) begin
          backed[h]  = 1'b0;
          held_total = held_total - HELD_W'(sz);
          r.drop     = 1'b1;
        end
        link_next[h] = list_head[c];
        list_head[c] = h;
        r.handle     = h;
        r.bytes      = sz;
        r.cls        = CLASS_W'(c);
      end
    end
    r.held = held_total;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [47:0] due_v,
                             input logic [47:0] seen_v);
    if (seen_v !== due_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, due_v, seen_v);
    end
  endtask

  // Sample all three channels at the clock edge.
  always @(posedge clk) begin
    grant_t due;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        list_head[c] = '0;
        list_free[c] = '0;
      end
      for (int n = 0; n < NODE_COUNT; n++) begin
        busy[n]   = 1'b0;
        backed[n] = 1'b0;
      end
      created    = '0;
      held_total = '0;
      free_limit = HOLD_FREE_LIMIT_RST;
      byte_limit = HOLD_BYTE_LIMIT_RST;
      grant_q.delete();
      errors = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_HOLD_FREE_LIMIT: free_limit = cfg_data[FLIM_W-1:0];
          REG_HOLD_BYTE_LIMIT: byte_limit = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (grant_q.size() == 0) begin
          errors++;
          $display("%0t: result transaction with none expected, status %0h handle %0h",
                   $time, out_status, out_granted_handle);
        end else begin
          due = grant_q.pop_front();
          check_field("status", due.status, out_status);
          check_field("granted_handle", due.handle, out_granted_handle);
          check_field("granted_bytes", due.bytes, out_granted_bytes);
          check_field("size_class", due.cls, out_size_class);
          check_field("needs_backing", due.needs, out_needs_backing);
          check_field("drop_backing", due.drop, out_drop_backing);
          check_field("held_bytes", due.held, out_held_bytes);
        end
      end
      if (in_valid && !in_stall)
        grant_q.push_back(serve_request(in_req_type, in_request_bytes, in_release_handle));
    end
    pending    <= grant_q.size();
    nodes_made <= int'(created);
    fail_count <= errors;
  end

endmodule

`default_nettype wire

>>> sim/tb_top.sv
`default_nettype none

module tb_top;
  import scpa_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 150;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  wire                 in_stall;
  logic                in_req_type;
  logic [REQ_W-1:0]    in_request_bytes;
  logic [HANDLE_W-1:0] in_release_handle;
  wire                 out_valid;
  logic                out_stall;
  wire  [1:0]          out_status;
  wire  [HANDLE_W-1:0] out_granted_handle;
  wire  [BYTES_W-1:0]  out_granted_bytes;
  wire  [CLASS_W-1:0]  out_size_class;
  wire                 out_needs_backing;
  wire                 out_drop_backing;
  wire  [HELD_W-1:0]   out_held_bytes;
  logic                cfg_valid;
  wire                 cfg_ready;
  logic                cfg_index;
  logic [BLIM_W-1:0]   cfg_data;

  int fail_count;
  int pending;
  int nodes_made;
  int cycles;
  int squeeze_req;
  bit calm;

  size_class_pool_allocator u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_request_bytes   (in_request_bytes),
    .in_release_handle  (in_release_handle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_granted_handle (out_granted_handle),
    .out_granted_bytes  (out_granted_bytes),
    .out_size_class     (out_size_class),
    .out_needs_backing  (out_needs_backing),
    .out_drop_backing   (out_drop_backing),
    .out_held_bytes     (out_held_bytes),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  alloc_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_req_type        (in_req_type),
    .in_request_bytes   (in_request_bytes),
    .in_release_handle  (in_release_handle),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_granted_handle (out_granted_handle),
    .out_granted_bytes  (out_granted_bytes),
    .out_size_class     (out_size_class),
    .out_needs_backing  (out_needs_backing),
    .out_drop_backing   (out_drop_backing),
    .out_held_bytes     (out_held_bytes),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .pending            (pending),
    .nodes_made         (nodes_made)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_top NOT OK");
    $finish;
  end

  // Result side: random stalls, none while calm, and long hold-offs on request.
  initial begin
    int served;
    int held;
    served = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_req > served) begin
        served++;
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk);
      end else begin
        out_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
      end
    end
  end

  // Offers one request transaction and waits until the block takes it.
  task automatic send_request(input req_type_t rtype, input logic [REQ_W-1:0] nbytes,
                              input logic [HANDLE_W-1:0] handle);
    while (!calm && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_req_type       <= rtype;
    in_request_bytes  <= nbytes;
    in_release_handle <= handle;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Writes both hold registers back to back with the channel held valid.
  task automatic set_limits(input logic [FLIM_W-1:0] flim, input logic [BLIM_W-1:0] blim);
    cfg_valid <= 1'b1;
    cfg_index <= REG_HOLD_FREE_LIMIT;
    cfg_data  <= BLIM_W'(flim);
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_HOLD_BYTE_LIMIT;
    cfg_data  <= blim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Byte counts near class edges, zero, and a few beyond the largest class.
  function automatic logic [REQ_W-1:0] pick_bytes();
    int          r;
    int          c;
    int unsigned hi;
    int unsigned lo;
    r = $urandom_range(99);
    if (r < 8) return REQ_W'($urandom);
    if (r < 12) return '0;
    c  = $urandom_range(NUM_CLASSES - 1);
    hi = MIN_CLASS_BYTES << (2 * c);
    lo = (c == 0) ? 0 : hi >> 2;
    if (r < 35) return REQ_W'(hi);
    return REQ_W'($urandom_range(hi, lo + 1));
  endfunction

  // Mostly handles that were created, some anywhere in the field's range.
  function automatic logic [HANDLE_W-1:0] pick_handle();
    if (nodes_made > 0 && $urandom_range(99) < 85)
      return HANDLE_W'($urandom_range(nodes_made - 1));
    return HANDLE_W'($urandom);
  endfunction

  task automatic random_request(input int alloc_pct);
    if ($urandom_range(99) < alloc_pct)
      send_request(REQ_ALLOC, pick_bytes(), HANDLE_W'($urandom));
    else
      send_request(REQ_FREE, REQ_W'($urandom), pick_handle());
  endtask

  initial begin
    int n;
    rst_n             <= 1'b0;
    in_valid          <= 1'b0;
    in_req_type       <= REQ_ALLOC;
    in_request_bytes  <= '0;
    in_release_handle <= '0;
    cfg_valid         <= 1'b0;
    cfg_index         <= REG_HOLD_FREE_LIMIT;
    cfg_data          <= '0;
    calm              <= 1'b0;
    squeeze_req       <= 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset limits: class edges, oversize requests,
    // a handle never created, a double free and a pop from a class list.
    send_request(REQ_ALLOC, 24'd0, '0);
    send_request(REQ_ALLOC, 24'd16, '1);
    send_request(REQ_ALLOC, 24'd17, '0);
    send_request(REQ_ALLOC, 24'd262144, '0);
    send_request(REQ_ALLOC, 24'd262145, '0);
    send_request(REQ_ALLOC, 24'hFFFFFF, '1);
    send_request(REQ_ALLOC, 24'd257, '0);
    send_request(REQ_ALLOC, 24'd4096, '0);
    send_request(REQ_ALLOC, 24'd16385, '0);
    send_request(REQ_FREE, '0, 10'd1023);
    send_request(REQ_FREE, '1, 10'd1);
    send_request(REQ_FREE, '0, 10'd1);
    send_request(REQ_ALLOC, 24'd5, '0);
    drain();

    // With both limits at zero every free drops its backing, and a pop of
    // such a node must attach fresh backing.
    set_limits('0, '0);
    send_request(REQ_FREE, '0, 10'd3);
    send_request(REQ_ALLOC, 24'd200000, '0);
    send_request(REQ_FREE, '0, 10'd0);
    send_request(REQ_FREE, '0, 10'd1);
    send_request(REQ_ALLOC, 24'd1, '0);
    send_request(REQ_ALLOC, 24'd1, '0);
    send_request(REQ_ALLOC, 24'd1, '0);
    drain();

    // Mixed traffic with small limits, a calm stretch, a long result
    // hold-off and one full drain in the middle.
    set_limits(10'd3, 32'd1000);
    for (n = 0; n < 350; n++) begin
      if (n == 50) squeeze_req <= squeeze_req + 1;
      if (n == 100) calm <= 1'b1;
      if (n == 220) calm <= 1'b0;
      if (n == 300) drain();
      random_request(55);
    end
    drain();

    // Zero limits: backing is dropped on every free.
    set_limits('0, '0);
    for (n = 0; n < 300; n++) random_request(50);
    drain();

    // Largest limits: nothing is dropped. Allocation-heavy until the node
    // table is full, then a while longer so that requests run into it.
    set_limits('1, '1);
    squeeze_req <= squeeze_req + 1;
    n = 0;
    while (nodes_made < NODE_COUNT && n < 1600) begin
      random_request(92);
      n++;
    end
    for (n = 0; n < 80; n++) random_request(70);
    drain();

    // Back to the reset values with a full table.
    set_limits(HOLD_FREE_LIMIT_RST, HOLD_BYTE_LIMIT_RST);
    for (n = 0; n < 250; n++) random_request(45);
    drain();

    // Let any stray result show up before the verdict.
    repeat (20) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
